[rtl/b64d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants of the Base64 stream decoder: character codes,
// symbol classes and the item that travels from classifier to decode stage.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // character codes of the Base64 alphabet
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'd48;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'd57;
  localparam logic [7:0] CHAR_PLUS    = 8'd43;
  localparam logic [7:0] CHAR_SLASH   = 8'd47;
  localparam logic [7:0] CHAR_PAD     = 8'd61;

  // symbol values that start each range of the alphabet
  localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
  localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SYM_PLUS_VAL   = 6'd62;
  localparam logic [5:0] SYM_SLASH_VAL  = 6'd63;

  // accumulator geometry
  localparam int unsigned ACC_W   = 12;
  localparam int unsigned CNT_W   = 4;
  localparam logic [CNT_W-1:0] BYTE_BITS = 4'd8;
  localparam logic [CNT_W-1:0] SYM_BITS  = 4'd6;
  localparam logic [CNT_W-1:0] PAD_BITS  = 4'd2;

  // queue between classifier and decode stage
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_SYMBOL,
    KIND_PAD,
    KIND_INVALID
  } sym_kind_t;

  typedef struct packed {
    sym_kind_t  kind;
    logic [5:0] value;
    logic       last;
  } sym_item_t;

  typedef struct packed {
    logic has_byte;
    logic ascii_error;
  } result_flags_t;

endpackage

[rtl/b64d_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Character classifier: maps one raw character to its symbol class and its
// 6-bit value, ready to enter the queue.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic [7:0]          char_code,
  input  logic                last_char,
  output b64d_pkg::sym_item_t item
);
  import b64d_pkg::*;

  // alphabet lookup
  always_comb begin
    item.last  = last_char;
    item.kind  = KIND_INVALID;
    item.value = '0;
    case (char_code) inside
      [CHAR_UPPER_A:CHAR_UPPER_Z]: begin
        item.kind  = KIND_SYMBOL;
        item.value = 6'(char_code - CHAR_UPPER_A);
      end
      [CHAR_LOWER_A:CHAR_LOWER_Z]: begin
        item.kind  = KIND_SYMBOL;
        item.value = 6'(char_code - CHAR_LOWER_A) + SYM_LOWER_BASE;
      end
      [CHAR_DIGIT_0:CHAR_DIGIT_9]: begin
        item.kind  = KIND_SYMBOL;
        item.value = 6'(char_code - CHAR_DIGIT_0) + SYM_DIGIT_BASE;
      end
      CHAR_PLUS: begin
        item.kind  = KIND_SYMBOL;
        item.value = SYM_PLUS_VAL;
      end
      CHAR_SLASH: begin
        item.kind  = KIND_SYMBOL;
        item.value = SYM_SLASH_VAL;
      end
      CHAR_PAD: begin
        item.kind = KIND_PAD;
      end
      default: begin
        item.kind = KIND_INVALID;
      end
    endcase
  end

endmodule

[rtl/b64d_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_queue
// Short register queue of classified characters between the classifier and
// the decode stage.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64d_pkg::sym_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output b64d_pkg::sym_item_t head
);
  import b64d_pkg::*;

  sym_item_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/b64d_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Decode stage: bit accumulator, byte extraction, ascii check and stop
// handling, with the output register of the result channel.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  b64d_pkg::sym_item_t   item,
  output logic                  item_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output b64d_pkg::result_flags_t out_flags,
  output logic                  out_last
);
  import b64d_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             stopped;
  logic             stopped_next;

  logic [ACC_W-1:0] acc_app;
  logic [CNT_W-1:0] cnt_app;
  logic             appended;
  logic [2:0]       shift;
  logic [7:0]       byte_val;
  logic [7:0]       res_byte;
  result_flags_t    res_flags;

  // take the next item when the output register is free or being drained
  assign item_pop = item_valid && (!out_valid || out_ready);

  // append the symbol or pad bits and extract a complete byte
  always_comb begin
    acc_app  = acc;
    cnt_app  = cnt;
    appended = 1'b0;
    case (item.kind)
      KIND_SYMBOL: begin
        acc_app  = {acc[ACC_W-7:0], item.value};
        cnt_app  = cnt + SYM_BITS;
        appended = 1'b1;
      end
      KIND_PAD: begin
        acc_app  = {acc[ACC_W-3:0], 2'b00};
        cnt_app  = cnt + PAD_BITS;
        appended = 1'b1;
      end
      default: begin
        appended = 1'b0;
      end
    endcase
    shift    = 3'(cnt_app - BYTE_BITS);
    byte_val = 8'(acc_app >> shift);
  end

  // state and result of this character
  always_comb begin
    acc_next     = acc;
    cnt_next     = cnt;
    stopped_next = stopped;
    res_byte     = '0;
    res_flags    = '0;
    if (!stopped) begin
      acc_next = acc_app;
      cnt_next = cnt_app;
      if (!appended) begin
        stopped_next = 1'b1;
      end
      if (appended && cnt_app >= BYTE_BITS) begin
        cnt_next = CNT_W'(shift);
        acc_next = acc_app & ~({ACC_W{1'b1}} << shift);
        res_byte = byte_val;
        if (byte_val[7]) begin
          res_flags.ascii_error = 1'b1;
          stopped_next          = 1'b1;
        end else begin
          res_flags.has_byte = 1'b1;
        end
      end
      if (item.kind == KIND_PAD) begin
        stopped_next = 1'b1;
      end
    end
    if (item.last) begin
      acc_next     = '0;
      cnt_next     = '0;
      stopped_next = 1'b0;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      cnt     <= '0;
      stopped <= 1'b0;
    end else if (item_pop) begin
      acc     <= acc_next;
      cnt     <= cnt_next;
      stopped <= stopped_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (item_pop) begin
      out_byte  <= res_byte;
      out_flags <= res_flags;
      out_last  <= item.last;
    end
  end

endmodule

[rtl/base64_stream_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Base64 text decoder: one character in, one result out per transfer.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tdata is the raw character, s_tlast marks the last
// character of a string. Output channel m_*: m_tdata is the decoded byte,
// m_tuser[0] says a byte is present, m_tuser[1] flags a byte of 128 or more
// (decoding of the string stops), m_tlast echoes s_tlast.
// Every character yields exactly one result transfer, in order.
// A character accepted on s_* passes through the queue and the output register
// before its result shows on m_*. Throughput: one character per cycle while
// m_tready is high, set by the accumulator update in the decode stage.
// A two-entry queue separates the classifier from the decode stage, and the
// result sits in an output register, so s_tready stays high while a result
// waits as long as the queue has room. When the receiver holds m_tready low
// the queue fills and s_tready drops once it holds two characters.
// Reset clears the queue, the output valid, the accumulator, the bit
// count and the stop flag; s_tready is high right after reset.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,   // last_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_byte
  output logic [1:0] m_tuser,   // [0] has_byte, [1] ascii_error
  output logic       m_tlast    // string_end
);
  import b64d_pkg::*;

  sym_item_t     front_item;
  sym_item_t     head_item;
  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  logic          q_push;
  result_flags_t flags;

  // input transfer pushes into the queue
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  b64d_front u_front (
    .char_code (s_tdata),
    .last_char (s_tlast),
    .item      (front_item)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_item)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_not_empty),
    .item       (head_item),
    .item_pop   (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_flags  (flags),
    .out_last   (m_tlast)
  );

  // result flags onto tuser
  assign m_tuser = {flags.ascii_error, flags.has_byte};

endmodule

[rtl/b64d_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the Base64 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // no result right after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // byte and error never together
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("byte and ascii error both set");

  // a delivered byte is ascii, an error byte is not
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata[7] == m_tuser[1])
    else $error("ascii check disagrees with byte value");

  // an empty result carries a zero byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] && !m_tuser[1] |-> m_tdata == 8'd0)
    else $error("empty result with nonzero byte");

endmodule

bind base64_stream_decoder_top b64d_checker u_checker (.*);
